### sv/tcelr_pkg.sv
// Package for the tick clocked event loop recorder.
// Holds widths, register indexes, command codes and reset values.
// No dependencies.
package tcelr_pkg;

    localparam int MAX_LOOP_TICKS = 16384;
    localparam int MESSAGE_BITS   = 24;
    localparam int PHASE_BITS     = 24;
    localparam int POS_BITS       = $clog2(MAX_LOOP_TICKS);
    localparam int LEN_BITS       = 15;
    localparam int CMD_BITS       = 2;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = 24;
    localparam int OUT_RAW_BITS   = MESSAGE_BITS + 1 + POS_BITS;
    localparam int OUT_DATA_BITS  = ((OUT_RAW_BITS + 7) / 8) * 8;
    localparam int IN_DATA_BITS   = ((MESSAGE_BITS + 7) / 8) * 8;

    localparam logic [CMD_BITS-1:0] CMD_SAMPLE = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_WRITE  = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_READ   = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] REG_PHASE_INC = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_LOOP_LEN  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_OVERWRITE = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_EMPTY_MSG = 2'd3;

    localparam logic [PHASE_BITS-1:0]   RST_PHASE_INC = 24'd671089;
    localparam logic [LEN_BITS-1:0]     RST_LOOP_LEN  = 15'd15360;
    localparam logic                    RST_OVERWRITE = 1'b1;
    localparam logic [MESSAGE_BITS-1:0] RST_EMPTY_MSG = '0;

    localparam logic [LEN_BITS-1:0] MAX_LEN = LEN_BITS'(MAX_LOOP_TICKS);

endpackage

### sv/tick_clocked_event_loop_recorder.sv
// An accepted input beat's result is registered, in the output register or the skid stage.
// Throughput: one beat per cycle while o_s_tready is high; a two-deep output register and
// skid stage keep accepting while a result waits. A tick writes and reads the loop store
// in the same cycle. Reset: synchronous, active low. It restores the register defaults and
// then runs a clearing pass over the 16384-entry loop store with o_s_tready low.
module tick_clocked_event_loop_recorder (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    input  logic [tcelr_pkg::IN_DATA_BITS-1:0]    i_s_tdata,   // message
    input  logic [tcelr_pkg::CMD_BITS-1:0]        i_s_tuser,   // cmd
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    output logic [tcelr_pkg::OUT_DATA_BITS-1:0]   o_m_tdata,   // read_message, tick_happened, position, pad
    input  logic                                  i_cfg_we,
    input  logic [tcelr_pkg::CFG_IDX_BITS-1:0]    i_cfg_addr,
    input  logic [tcelr_pkg::CFG_DATA_BITS-1:0]   i_cfg_wdata
);

    localparam int MB = tcelr_pkg::MESSAGE_BITS;
    localparam int PB = tcelr_pkg::PHASE_BITS;
    localparam int AB = tcelr_pkg::POS_BITS;
    localparam int LB = tcelr_pkg::LEN_BITS;
    localparam int OB = tcelr_pkg::OUT_DATA_BITS;

    logic [PB-1:0] r_inc;
    logic [LB-1:0] r_len;
    logic          r_ovw;
    logic [MB-1:0] r_empty;

    logic [PB-1:0] r_phase;
    logic [AB-1:0] r_pos;
    logic [MB-1:0] r_pend_wr;
    logic [MB-1:0] r_pend_rd;
    logic          r_pr_mem;
    logic [MB-1:0] r_mem_q;
    logic          r_clearing;
    logic [AB-1:0] r_clr_cnt;

    logic [MB-1:0] mem [tcelr_pkg::MAX_LOOP_TICKS];

    logic          r_out_v;
    logic [OB-1:0] r_out_d;
    logic          r_skd_v;
    logic [OB-1:0] r_skd_d;

    logic               fire;
    logic [1:0]         cmd;
    logic [MB-1:0]      msg;
    logic [PB:0]        sum;
    logic               tick;
    logic [LB-1:0]      eff_len;
    logic [LB-1:0]      pos_inc;
    logic [AB-1:0]      pos_new;
    logic               wr_have;
    logic               wr_en;
    logic [MB-1:0]      wr_val;
    logic               same_slot;
    logic               rd_en;
    logic [MB-1:0]      pr_eff;
    logic [MB-1:0]      res_rd;
    logic [AB-1:0]      res_pos;
    logic [OB-1:0]      res;
    logic               mem_we;
    logic [AB-1:0]      mem_waddr;
    logic [MB-1:0]      mem_wdata;

    assign o_s_tready = !r_skd_v && !r_clearing;
    assign fire       = i_s_tvalid && o_s_tready;
    assign cmd        = i_s_tuser;
    assign msg        = i_s_tdata[MB-1:0];

    always_comb begin
        sum = {1'b0, r_phase} + {1'b0, r_inc};
        tick = fire && (cmd == tcelr_pkg::CMD_SAMPLE) && sum[PB];
        if (r_len == '0) begin
            eff_len = LB'(1);
        end else if (r_len > tcelr_pkg::MAX_LEN) begin
            eff_len = tcelr_pkg::MAX_LEN;
        end else begin
            eff_len = r_len;
        end
        pos_inc = {{(LB-AB){1'b0}}, r_pos} + LB'(1);
        pos_new = (pos_inc >= eff_len) ? '0 : pos_inc[AB-1:0];
        wr_have = r_pend_wr != r_empty;
        wr_en = tick && (wr_have || r_ovw);
        wr_val = wr_have ? r_pend_wr : r_empty;
        same_slot = pos_new == r_pos;
        rd_en = tick && !(same_slot && wr_en);
        pr_eff = r_pr_mem ? r_mem_q : r_pend_rd;
        res_rd = (cmd == tcelr_pkg::CMD_READ) ? pr_eff : r_empty;
        res_pos = tick ? pos_new : r_pos;
        res = OB'({res_pos, tick, res_rd});
        mem_we = r_clearing || wr_en;
        mem_waddr = r_clearing ? r_clr_cnt : r_pos;
        mem_wdata = r_clearing ? tcelr_pkg::RST_EMPTY_MSG : wr_val;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_mem_q <= mem[pos_new];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inc   <= tcelr_pkg::RST_PHASE_INC;
            r_len   <= tcelr_pkg::RST_LOOP_LEN;
            r_ovw   <= tcelr_pkg::RST_OVERWRITE;
            r_empty <= tcelr_pkg::RST_EMPTY_MSG;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                tcelr_pkg::REG_PHASE_INC: r_inc   <= i_cfg_wdata[PB-1:0];
                tcelr_pkg::REG_LOOP_LEN:  r_len   <= i_cfg_wdata[LB-1:0];
                tcelr_pkg::REG_OVERWRITE: r_ovw   <= i_cfg_wdata[0];
                tcelr_pkg::REG_EMPTY_MSG: r_empty <= i_cfg_wdata[MB-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clearing) begin
            r_clr_cnt <= r_clr_cnt + AB'(1);
            if (r_clr_cnt == '1) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_pos     <= '0;
            r_pend_wr <= tcelr_pkg::RST_EMPTY_MSG;
            r_pend_rd <= tcelr_pkg::RST_EMPTY_MSG;
            r_pr_mem  <= 1'b0;
        end else if (fire) begin
            case (cmd)
                tcelr_pkg::CMD_SAMPLE: begin
                    r_phase <= sum[PB-1:0];
                    if (tick) begin
                        r_pos <= pos_new;
                        if (wr_have) begin
                            r_pend_wr <= r_empty;
                        end
                        if (rd_en) begin
                            r_pr_mem <= 1'b1;
                        end else begin
                            r_pr_mem  <= 1'b0;
                            r_pend_rd <= wr_val;
                        end
                    end
                end
                tcelr_pkg::CMD_WRITE: begin
                    r_pend_wr <= msg;
                end
                tcelr_pkg::CMD_READ: begin
                    r_pend_rd <= r_empty;
                    r_pr_mem  <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_skd_v <= 1'b0;
        end else if (fire) begin
            if (!r_out_v || i_m_tready) begin
                r_out_v <= 1'b1;
                r_out_d <= res;
            end else begin
                r_skd_v <= 1'b1;
                r_skd_d <= res;
            end
        end else if (r_out_v && i_m_tready) begin
            r_out_v <= r_skd_v;
            r_out_d <= r_skd_d;
            r_skd_v <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out_d;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_v |-> r_out_v)
        else $error("Skid stage holds a beat while the output register is empty.");

    a_no_output_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> (!r_out_v && !r_pr_mem))
        else $error("Result or store read present during the clearing pass.");

    a_tick_loads_pending_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |=> r_pr_mem)
        else $error("Store read on a tick did not become the pending read.");

    a_accept_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !r_out_v) |=> r_out_v)
        else $error("Accepted beat produced no result beat.");

endmodule

### tb/tick_clocked_event_loop_recorder_tb.sv
// Self-checking testbench for the tick clocked event loop recorder: a clocked driver and
// monitor around the block, a model of the phase accumulator and loop store, and a
// field-by-field check of every result beat. Depends on tcelr_pkg and the block itself.
module tick_clocked_event_loop_recorder_tb;

    localparam int MB = tcelr_pkg::MESSAGE_BITS;
    localparam int PB = tcelr_pkg::PHASE_BITS;
    localparam int AB = tcelr_pkg::POS_BITS;
    localparam int LB = tcelr_pkg::LEN_BITS;
    localparam int CB = tcelr_pkg::CMD_BITS;
    localparam int XB = tcelr_pkg::CFG_IDX_BITS;
    localparam int DB = tcelr_pkg::CFG_DATA_BITS;

    localparam logic [CB-1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASES      = 8;
    localparam int PHASE_BEATS = 228;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [CB-1:0] cmd;
        logic [MB-1:0] msg;
    } t_cmd_beat;

    typedef struct packed {
        logic [MB-1:0] rd_msg;
        logic          tick;
        logic [AB-1:0] pos;
    } t_loop_out;

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 i_s_tvalid;
    logic                                 o_s_tready;
    logic [tcelr_pkg::IN_DATA_BITS-1:0]   i_s_tdata;
    logic [CB-1:0]                        i_s_tuser;
    logic                                 o_m_tvalid;
    logic                                 i_m_tready;
    logic [tcelr_pkg::OUT_DATA_BITS-1:0]  o_m_tdata;
    logic                                 i_cfg_we;
    logic [XB-1:0]                        i_cfg_addr;
    logic [DB-1:0]                        i_cfg_wdata;

    tick_clocked_event_loop_recorder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    logic [PB-1:0] m_inc;
    logic [LB-1:0] m_len;
    logic          m_ow;
    logic [MB-1:0] m_empty;
    logic [PB-1:0] m_phase;
    logic [AB-1:0] m_pos;
    logic [MB-1:0] m_wr;
    logic [MB-1:0] m_rd;
    logic [MB-1:0] m_store [tcelr_pkg::MAX_LOOP_TICKS];

    t_cmd_beat cmd_beats_q[$];
    t_loop_out tick_results_q[$];
    t_cmd_beat drv_beat;
    t_cmd_beat mon_beat;
    t_loop_out got;
    t_loop_out want;
    int        src_idle_pct;
    int        sink_stall_pct;
    bit        in_taken;
    int        err_count;
    int        cyc_count;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_loop_out recorder_step(t_cmd_beat b);
        logic [PB:0] sum;
        logic [LB:0] len_eff;
        logic [LB:0] next_pos;
        t_loop_out   r;
        r.rd_msg = m_empty;
        r.tick = 1'b0;
        case (b.cmd)
            tcelr_pkg::CMD_SAMPLE: begin
                sum = {1'b0, m_phase} + {1'b0, m_inc};
                if (sum[PB]) begin
                    r.tick = 1'b1;
                    if (m_wr != m_empty) begin
                        m_store[m_pos] = m_wr;
                        m_wr = m_empty;
                    end else if (m_ow) begin
                        m_store[m_pos] = m_empty;
                    end
                    if (m_len == '0) begin
                        len_eff = (LB+1)'(1);
                    end else if (m_len > tcelr_pkg::MAX_LEN) begin
                        len_eff = (LB+1)'(tcelr_pkg::MAX_LEN);
                    end else begin
                        len_eff = (LB+1)'(m_len);
                    end
                    next_pos = (LB+1)'(m_pos) + (LB+1)'(1);
                    m_pos = (next_pos >= len_eff) ? '0 : next_pos[AB-1:0];
                    m_rd = m_store[m_pos];
                end
                m_phase = sum[PB-1:0];
            end
            tcelr_pkg::CMD_WRITE: begin
                m_wr = b.msg;
            end
            tcelr_pkg::CMD_READ: begin
                r.rd_msg = m_rd;
                m_rd = m_empty;
            end
            default: begin
            end
        endcase
        r.pos = m_pos;
        return r;
    endfunction

    function automatic void add_beat(logic [CB-1:0] cmd, logic [MB-1:0] msg);
        t_cmd_beat b;
        b.cmd = cmd;
        b.msg = msg;
        cmd_beats_q.push_back(b);
    endfunction

    task automatic write_reg(input logic [XB-1:0] idx,
                             input logic [DB-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            tcelr_pkg::REG_PHASE_INC: m_inc = val[PB-1:0];
            tcelr_pkg::REG_LOOP_LEN:  m_len = val[LB-1:0];
            tcelr_pkg::REG_OVERWRITE: m_ow = val[0];
            tcelr_pkg::REG_EMPTY_MSG: m_empty = val[MB-1:0];
            default: begin
            end
        endcase
    endtask

    task automatic setup_loop(input logic [DB-1:0] inc,
                              input logic [DB-1:0] len,
                              input logic [DB-1:0] ow,
                              input logic [DB-1:0] empty_code);
        write_reg(tcelr_pkg::REG_PHASE_INC, inc);
        write_reg(tcelr_pkg::REG_LOOP_LEN, len);
        write_reg(tcelr_pkg::REG_OVERWRITE, ow);
        write_reg(tcelr_pkg::REG_EMPTY_MSG, empty_code);
    endtask

    task automatic drain_all();
        while (cmd_beats_q.size() != 0 || i_s_tvalid || tick_results_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (3) @(posedge i_clk);
    endtask

    // Mostly write, a few samples, then a read, so that recorded events come back
    // around the loop; the rest is loose commands of every kind.
    task automatic queue_traffic(input int count);
        int n;
        int k;
        n = 0;
        while (n < count) begin
            if ($urandom_range(99) < 70) begin
                if ($urandom_range(9) == 0) begin
                    add_beat(tcelr_pkg::CMD_WRITE, m_empty);
                end else begin
                    add_beat(tcelr_pkg::CMD_WRITE, MB'($urandom));
                end
                k = $urandom_range(1, 4);
                repeat (k) add_beat(tcelr_pkg::CMD_SAMPLE, MB'($urandom));
                add_beat(tcelr_pkg::CMD_READ, MB'($urandom));
                n = n + k + 2;
            end else begin
                add_beat(CB'($urandom_range(3)), MB'($urandom));
                n = n + 1;
            end
        end
    endtask

    always @(negedge i_clk) begin
        if (!i_s_tvalid || in_taken) begin
            if (cmd_beats_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                drv_beat = cmd_beats_q.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= drv_beat.msg;
                i_s_tuser  <= drv_beat.cmd;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
        i_m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        cyc_count = cyc_count + 1;
        in_taken = i_rst_n && i_s_tvalid && o_s_tready;
        if (in_taken) begin
            mon_beat.cmd = i_s_tuser;
            mon_beat.msg = i_s_tdata[MB-1:0];
            tick_results_q.push_back(recorder_step(mon_beat));
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.rd_msg = o_m_tdata[MB-1:0];
            got.tick   = o_m_tdata[MB];
            got.pos    = o_m_tdata[MB+1 +: AB];
            if (tick_results_q.size() == 0) begin
                err_count = err_count + 1;
                if (err_count <= MAX_REPORTS) begin
                    $display("Unexpected result beat: msg %h tick %b pos %0d",
                             got.rd_msg, got.tick, got.pos);
                end
            end else begin
                want = tick_results_q.pop_front();
                if (got.rd_msg !== want.rd_msg || got.tick !== want.tick
                        || got.pos !== want.pos) begin
                    err_count = err_count + 1;
                    if (err_count <= MAX_REPORTS) begin
                        $display("Mismatch: msg %h/%h tick %b/%b pos %0d/%0d (expected/actual)",
                                 want.rd_msg, got.rd_msg, want.tick, got.tick,
                                 want.pos, got.pos);
                    end
                end
            end
        end
        if (cyc_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        i_s_tuser      = '0;
        i_m_tready     = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_addr     = '0;
        i_cfg_wdata    = '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        in_taken       = 1'b0;
        err_count      = 0;
        cyc_count      = 0;
        m_inc   = tcelr_pkg::RST_PHASE_INC;
        m_len   = tcelr_pkg::RST_LOOP_LEN;
        m_ow    = tcelr_pkg::RST_OVERWRITE;
        m_empty = tcelr_pkg::RST_EMPTY_MSG;
        m_phase = '0;
        m_pos   = '0;
        m_wr    = tcelr_pkg::RST_EMPTY_MSG;
        m_rd    = tcelr_pkg::RST_EMPTY_MSG;
        for (int i = 0; i < tcelr_pkg::MAX_LOOP_TICKS; i++) begin
            m_store[i] = tcelr_pkg::RST_EMPTY_MSG;
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);

        // Reset settings first, then a short loop with the fastest tick rate.
        add_beat(tcelr_pkg::CMD_SAMPLE, 24'h000000);
        add_beat(tcelr_pkg::CMD_WRITE, 24'hFFFFFF);
        add_beat(tcelr_pkg::CMD_READ, 24'h000000);
        add_beat(CMD_UNUSED, 24'hFFFFFF);
        drain_all();

        setup_loop(24'hFFFFFF, 24'd3, 24'd1, 24'd0);
        add_beat(tcelr_pkg::CMD_WRITE, 24'hA5A5A5);
        add_beat(tcelr_pkg::CMD_SAMPLE, 24'h000000);
        add_beat(tcelr_pkg::CMD_SAMPLE, 24'h000000);
        add_beat(tcelr_pkg::CMD_READ, 24'h000000);
        add_beat(tcelr_pkg::CMD_SAMPLE, 24'h000000);
        add_beat(tcelr_pkg::CMD_SAMPLE, 24'h000000);
        add_beat(tcelr_pkg::CMD_READ, 24'h000000);
        add_beat(tcelr_pkg::CMD_READ, 24'h000000);
        add_beat(tcelr_pkg::CMD_WRITE, 24'h000000);
        add_beat(tcelr_pkg::CMD_SAMPLE, 24'h000000);
        add_beat(tcelr_pkg::CMD_WRITE, 24'h5A5A5A);
        add_beat(CMD_UNUSED, 24'hFFFFFF);
        add_beat(tcelr_pkg::CMD_SAMPLE, 24'hFFFFFF);
        add_beat(tcelr_pkg::CMD_SAMPLE, 24'h000000);
        add_beat(tcelr_pkg::CMD_SAMPLE, 24'h000000);
        add_beat(tcelr_pkg::CMD_READ, 24'hFFFFFF);
        add_beat(tcelr_pkg::CMD_SAMPLE, 24'h000000);
        drain_all();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph % 4)
                0: begin
                    src_idle_pct = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct = 53;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct = 0;
                    sink_stall_pct = 53;
                end
                default: begin
                    src_idle_pct = 31;
                    sink_stall_pct = 31;
                end
            endcase
            case (ph)
                0: setup_loop(24'hFFFFFF, 24'd0, 24'd0, 24'hFFFFFF);
                1: setup_loop(24'd1, 24'd32767, 24'd1, 24'd0);
                2: setup_loop(DB'($urandom_range(24'h800000, 24'hFFFFFF)), 24'd16384, 24'd1,
                              DB'($urandom_range(24'hFFFFFF)));
                3: setup_loop(24'd671089, DB'($urandom_range(1, 8)), 24'd0, 24'd0);
                default: setup_loop(($urandom_range(1) == 1) ?
                                        DB'($urandom_range(24'h800000, 24'hFFFFFF)) :
                                        DB'($urandom_range(1, 24'hFFFFFF)),
                                    ($urandom_range(3) == 0) ?
                                        DB'($urandom_range(32767)) :
                                        DB'($urandom_range(1, 20)),
                                    DB'($urandom_range(1)),
                                    ($urandom_range(1) == 1) ?
                                        DB'(0) : DB'($urandom_range(24'hFFFFFF)));
            endcase
            queue_traffic(PHASE_BEATS / 2);
            drain_all();
            queue_traffic(PHASE_BEATS / 2);
            drain_all();
        end

        repeat (8) @(posedge i_clk);
        if (err_count == 0 && tick_results_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### files.f
sv/tcelr_pkg.sv
sv/tick_clocked_event_loop_recorder.sv
tb/tick_clocked_event_loop_recorder_tb.sv
